// File: design/truck_trailer_kinematics_macros.svh
// Assertion macros for the truck-trailer block.
`ifndef TRUCK_TRAILER_KINEMATICS_MACROS_SVH
`define TRUCK_TRAILER_KINEMATICS_MACROS_SVH
`ifndef SYNTH
`define TT_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
`define TT_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define TT_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define TT_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

// File: design/tt_pkg.sv
package tt_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int VALUE_WIDTH   = 32;
   localparam int NUM_RESULTS   = 13;
   localparam int DIV_STEPS     = 31;

   localparam int ANG_W   = 36;
   localparam int ZW      = 34;
   localparam int XY_W    = 34;
   localparam int NUM_W   = XY_W + 16;
   localparam int DEN_W   = XY_W;
   localparam int REM_W   = DEN_W + 1;
   localparam int Q16_W   = 18;
   localparam int PROD_W  = 48;
   localparam int P66_W   = 66;

   localparam int CORDIC_LAT  = CORDIC_STAGES + 1;
   localparam int DIV_LAT     = DIV_STEPS + 2;
   localparam int PROD_STAGES = 5;
   localparam int PIPE_DEPTH  = 1 + CORDIC_LAT + 1 + DIV_LAT + PROD_STAGES;

   localparam int CNT_W = $clog2(NUM_RESULTS + 1);
   localparam int IDX_W = $clog2(NUM_RESULTS);

   localparam logic [0:0] CSR_INV_WHEELBASE    = 1'b0;
   localparam logic [0:0] CSR_INV_HITCH_LENGTH = 1'b1;
   localparam logic [15:0] INV_RESET = 16'd4096;

   localparam logic signed [ANG_W-1:0] Q30_PI      = 36'sd3373259426;
   localparam logic signed [ANG_W-1:0] Q30_TWO_PI  = 36'sd6746518852;
   localparam logic signed [ANG_W-1:0] Q30_HALF_PI = 36'sd1686629713;
   localparam logic signed [XY_W-1:0]  Q30_GAIN    = 34'sd652032874;

   localparam logic signed [31:0] TAN_LIMIT = 32'sh7fffffff;
   localparam logic signed [P66_W-1:0] PROD_LIMIT = 66'sd140737488355327;
   localparam logic signed [PROD_W-1:0] VAL_MAX =
      (48'sd1 <<< (VALUE_WIDTH - 1)) - 48'sd1;
   localparam logic signed [PROD_W-1:0] VAL_MIN = -VAL_MAX - 48'sd1;

   localparam logic signed [ZW-1:0] ATAN_Q30 [0:31] = '{
      34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158,
      34'sd67021686, 34'sd33543515, 34'sd16775850, 34'sd8388437,
      34'sd4194282, 34'sd2097149, 34'sd1048575, 34'sd524287,
      34'sd262143, 34'sd131071, 34'sd65535, 34'sd32767,
      34'sd16383, 34'sd8191, 34'sd4095, 34'sd2047,
      34'sd1023, 34'sd511, 34'sd255, 34'sd127,
      34'sd63, 34'sd31, 34'sd15, 34'sd7,
      34'sd3, 34'sd1, 34'sd0, 34'sd0
   };

   localparam logic       RES_KIND [0:NUM_RESULTS-1] = '{
      1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1
   };
   localparam logic [1:0] RES_ROW [0:NUM_RESULTS-1] = '{
      2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3, 2'd3, 2'd3
   };
   localparam logic [2:0] RES_COL [0:NUM_RESULTS-1] = '{
      3'd0, 3'd0, 3'd0, 3'd0, 3'd2, 3'd5, 3'd2, 3'd5, 3'd4, 3'd5, 3'd2, 3'd3, 3'd5
   };

   typedef struct packed {
      logic [Q16_W-1:0] cy;
      logic [Q16_W-1:0] sy;
      logic [Q16_W-1:0] sd;
      logic [Q16_W-1:0] cd;
      logic [15:0]      spd;
   } side_type;

   function automatic logic signed [Q16_W-1:0] q30_to_q16(input logic signed [XY_W-1:0] v);
      logic signed [XY_W-1:0] r;
      r = (v + 34'sd8192) >>> 14;
      if (r > 34'sd65536) r = 34'sd65536;
      else if (r < -34'sd65536) r = -34'sd65536;
      return r[Q16_W-1:0];
   endfunction

   // round half up at bit 8 or 12, then clamp to +-(2^47-1)
   function automatic logic signed [PROD_W-1:0] prod_round(input logic signed [P66_W-1:0] p,
                                                          input logic sel12);
      logic signed [P66_W-1:0] r;
      r = sel12 ? ((p + 66'sd2048) >>> 12) : ((p + 66'sd128) >>> 8);
      if (r > PROD_LIMIT) r = PROD_LIMIT;
      else if (r < -PROD_LIMIT) r = -PROD_LIMIT;
      return r[PROD_W-1:0];
   endfunction

   function automatic logic [31:0] sat_value(input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] r;
      r = v;
      if (r > VAL_MAX) r = VAL_MAX;
      else if (r < VAL_MIN) r = VAL_MIN;
      return r[31:0];
   endfunction

endpackage

// File: design/tt_req_if.sv
interface tt_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] yaw_angle;
   logic signed [15:0] hitch_angle;
   logic signed [15:0] steer_angle;
   logic signed [15:0] speed;

   modport source (output valid, yaw_angle, hitch_angle, steer_angle, speed, input ready);
   modport sink   (input valid, yaw_angle, hitch_angle, steer_angle, speed, output ready);
endinterface

// File: design/tt_rsp_if.sv
interface tt_rsp_if;
   logic               valid;
   logic               ready;
   logic               kind;
   logic [1:0]         row;
   logic [2:0]         column;
   logic signed [31:0] value;
   logic               last;

   modport source (output valid, kind, row, column, value, last, input ready);
   modport sink   (input valid, kind, row, column, value, last, output ready);
endinterface

// File: design/tt_cordic.sv
module tt_cordic (
   input  logic                             clock,
   input  logic                             en,
   input  logic signed [tt_pkg::ANG_W-1:0]  ang,
   output logic signed [tt_pkg::XY_W-1:0]   sin_q30,
   output logic signed [tt_pkg::XY_W-1:0]   cos_q30
);
   import tt_pkg::*;

   logic signed [XY_W-1:0] x_ff [0:CORDIC_STAGES];
   logic signed [XY_W-1:0] y_ff [0:CORDIC_STAGES];
   logic signed [ZW-1:0]   z_ff [0:CORDIC_STAGES];
   logic                   flip_ff [0:CORDIC_STAGES];

   logic signed [ANG_W-1:0] wrap;
   logic signed [ANG_W-1:0] z_in;
   logic                    flip_in;

   // bring into [-pi, pi], then fold into the right half plane
   always_comb begin
      if (ang > Q30_PI) wrap = ang - Q30_TWO_PI;
      else if (ang < -Q30_PI) wrap = ang + Q30_TWO_PI;
      else wrap = ang;
      flip_in = 1'b1;
      if (wrap > Q30_HALF_PI) z_in = wrap - Q30_PI;
      else if (wrap < -Q30_HALF_PI) z_in = wrap + Q30_PI;
      else begin
         z_in    = wrap;
         flip_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= Q30_GAIN;
         y_ff[0]    <= '0;
         z_ff[0]    <= z_in[ZW-1:0];
         flip_ff[0] <= flip_in;
      end
   end

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
      always_ff @(posedge clock) begin
         if (en) begin
            if (!z_ff[i][ZW-1]) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - ATAN_Q30[i];
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + ATAN_Q30[i];
            end
            flip_ff[i+1] <= flip_ff[i];
         end
      end
   end

   assign sin_q30 = flip_ff[CORDIC_STAGES] ? -y_ff[CORDIC_STAGES] : y_ff[CORDIC_STAGES];
   assign cos_q30 = flip_ff[CORDIC_STAGES] ? -x_ff[CORDIC_STAGES] : x_ff[CORDIC_STAGES];

endmodule

// File: design/tt_div.sv
module tt_div (
   input  logic                            clock,
   input  logic                            en,
   input  logic [tt_pkg::NUM_W-1:0]        num,
   input  logic [tt_pkg::DEN_W-1:0]        den,
   input  logic                            neg,
   output logic signed [31:0]              tan_q16
);
   import tt_pkg::*;

   logic [REM_W-1:0]     rem_ff [0:DIV_STEPS];
   logic [DEN_W-1:0]     den_ff [0:DIV_STEPS];
   logic [DIV_STEPS-1:0] lo_ff  [0:DIV_STEPS];
   logic [DIV_STEPS-1:0] q_ff   [0:DIV_STEPS];
   logic                 sat_ff [0:DIV_STEPS];
   logic                 neg_ff [0:DIV_STEPS];
   logic signed [31:0]   tan_ff;

   logic [NUM_W-1:0] num_hi;
   assign num_hi = num >> DIV_STEPS;

   // quotient of 2^31 or more saturates; zero divisor lands here too
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= num_hi[REM_W-1:0];
         den_ff[0] <= den;
         lo_ff[0]  <= num[DIV_STEPS-1:0];
         q_ff[0]   <= '0;
         sat_ff[0] <= (num_hi >= NUM_W'(den));
         neg_ff[0] <= neg;
      end
   end

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      logic [REM_W-1:0] r2;
      logic             ge;
      assign r2 = {rem_ff[k][REM_W-2:0], lo_ff[k][DIV_STEPS-1-k]};
      assign ge = (r2 >= {1'b0, den_ff[k]});
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= ge ? (r2 - {1'b0, den_ff[k]}) : r2;
            q_ff[k+1]   <= {q_ff[k][DIV_STEPS-2:0], ge};
            den_ff[k+1] <= den_ff[k];
            lo_ff[k+1]  <= lo_ff[k];
            sat_ff[k+1] <= sat_ff[k];
            neg_ff[k+1] <= neg_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (sat_ff[DIV_STEPS])
            tan_ff <= neg_ff[DIV_STEPS] ? -TAN_LIMIT : TAN_LIMIT;
         else if (neg_ff[DIV_STEPS])
            tan_ff <= -$signed({1'b0, q_ff[DIV_STEPS]});
         else
            tan_ff <= $signed({1'b0, q_ff[DIV_STEPS]});
      end
   end

   assign tan_q16 = tan_ff;

endmodule

// File: design/truck_trailer_kinematics.sv
// channel  dir  handshake     carries
// req_ch   in   valid/ready   yaw_angle, hitch_angle, steer_angle, speed
// rsp_ch   out  valid/ready   kind, row, column, value, last; 13 words per item
// csr      in   csr_we        inv_wheelbase (0), inv_hitch_length (1)
//
// Result words leave one a cycle while rsp_ch is ready; items overlap in the pipeline.
// The path to the first result word runs through the input stage, 17 CORDIC stages,
// the rounding stage, a 33-stage divider for tan and five product stages.
// Synchronous reset clears the valid line and the output counter; both CSRs go to 4096.
// The whole pipeline stalls while its last stage holds an item the serializer cannot take.
`include "truck_trailer_kinematics_macros.svh"
module truck_trailer_kinematics (
   input  logic        clock,
   input  logic        reset,
   tt_req_if.sink      req_ch,
   tt_rsp_if.source    rsp_ch,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import tt_pkg::*;

   localparam int LAST = PIPE_DEPTH - 1;

   logic [15:0] inv_wheelbase_ff, inv_hitch_length_ff;
   logic [PIPE_DEPTH-1:0] vld_ff;
   logic adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_wheelbase_ff    <= INV_RESET;
         inv_hitch_length_ff <= INV_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_INV_WHEELBASE:    inv_wheelbase_ff    <= csr_wdata;
            CSR_INV_HITCH_LENGTH: inv_hitch_length_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic signed [16:0] il_s, id_s;
   assign il_s = $signed({1'b0, inv_wheelbase_ff});
   assign id_s = $signed({1'b0, inv_hitch_length_ff});

   // serializer state
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [31:0]      val_ff [0:NUM_RESULTS-1];
   logic [31:0]      load_val [0:NUM_RESULTS-1];
   logic             ser_free, load, rsp_take;

   assign rsp_take = rsp_ch.valid && rsp_ch.ready;
   assign ser_free = (cnt_ff == '0) || (cnt_ff == CNT_W'(1) && rsp_ch.ready);
   assign adv      = !vld_ff[LAST] || ser_free;
   assign load     = adv && vld_ff[LAST];
   assign req_ch.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[PIPE_DEPTH-2:0], req_ch.valid};
   end

   // input stage
   logic signed [15:0] in_yaw_ff, in_hitch_ff, in_steer_ff, in_spd_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         in_yaw_ff   <= req_ch.yaw_angle;
         in_hitch_ff <= req_ch.hitch_angle;
         in_steer_ff <= req_ch.steer_angle;
         in_spd_ff   <= req_ch.speed;
      end
   end

   logic signed [16:0]      dlt;
   logic signed [ANG_W-1:0] ang_yaw, ang_dlt, ang_str;
   assign dlt     = 17'(in_hitch_ff) - 17'(in_yaw_ff);
   assign ang_yaw = ANG_W'(in_yaw_ff) <<< 17;
   assign ang_dlt = ANG_W'(dlt) <<< 17;
   assign ang_str = ANG_W'(in_steer_ff) <<< 17;

   logic signed [XY_W-1:0] ys, yc, ds, dc, ss, sc;
   tt_cordic u_cordic_yaw (.clock(clock), .en(adv), .ang(ang_yaw), .sin_q30(ys), .cos_q30(yc));
   tt_cordic u_cordic_dlt (.clock(clock), .en(adv), .ang(ang_dlt), .sin_q30(ds), .cos_q30(dc));
   tt_cordic u_cordic_str (.clock(clock), .en(adv), .ang(ang_str), .sin_q30(ss), .cos_q30(sc));

   logic signed [15:0] spd_dly_ff [0:CORDIC_LAT-1];
   always_ff @(posedge clock) begin
      if (adv) begin
         spd_dly_ff[0] <= in_spd_ff;
         for (int k = 1; k < CORDIC_LAT; k++) spd_dly_ff[k] <= spd_dly_ff[k-1];
      end
   end

   // rounding stage; steer goes to the divider as magnitudes and a sign
   side_type         side_f_ff;
   logic [NUM_W-1:0] f_num_ff;
   logic [DEN_W-1:0] f_den_ff;
   logic             f_neg_ff;
   logic [XY_W-1:0]  s_abs, c_abs;
   assign s_abs = ss[XY_W-1] ? XY_W'(-ss) : XY_W'(ss);
   assign c_abs = sc[XY_W-1] ? XY_W'(-sc) : XY_W'(sc);

   always_ff @(posedge clock) begin
      if (adv) begin
         side_f_ff.cy  <= q30_to_q16(yc);
         side_f_ff.sy  <= q30_to_q16(ys);
         side_f_ff.sd  <= q30_to_q16(ds);
         side_f_ff.cd  <= q30_to_q16(dc);
         side_f_ff.spd <= spd_dly_ff[CORDIC_LAT-1];
         f_num_ff      <= NUM_W'(s_abs) << 16;
         f_den_ff      <= c_abs;
         f_neg_ff      <= ss[XY_W-1] ^ sc[XY_W-1];
      end
   end

   logic signed [31:0] tan_q16;
   tt_div u_div (.clock(clock), .en(adv), .num(f_num_ff), .den(f_den_ff), .neg(f_neg_ff),
                 .tan_q16(tan_q16));

   side_type side_dly_ff [0:DIV_LAT-1];
   always_ff @(posedge clock) begin
      if (adv) begin
         side_dly_ff[0] <= side_f_ff;
         for (int k = 1; k < DIV_LAT; k++) side_dly_ff[k] <= side_dly_ff[k-1];
      end
   end

   side_type           sd_d;
   logic signed [15:0] v_d;
   assign sd_d = side_dly_ff[DIV_LAT-1];
   assign v_d  = $signed(sd_d.spd);

   // product stage 1
   logic signed [63:0] s1_sq_ff;
   logic signed [47:0] s1_tv_ff;
   logic signed [33:0] s1_cyv_ff, s1_syv_ff, s1_sdv_ff, s1_cdv_ff;
   logic signed [48:0] s1_til_ff;
   logic signed [34:0] s1_sdid_ff;
   logic signed [Q16_W-1:0] s1_cy_ff, s1_sy_ff;
   logic signed [15:0] s1_v_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_sq_ff   <= tan_q16 * tan_q16;
         s1_tv_ff   <= tan_q16 * v_d;
         s1_cyv_ff  <= $signed(sd_d.cy) * v_d;
         s1_syv_ff  <= $signed(sd_d.sy) * v_d;
         s1_sdv_ff  <= $signed(sd_d.sd) * v_d;
         s1_cdv_ff  <= $signed(sd_d.cd) * v_d;
         s1_til_ff  <= tan_q16 * il_s;
         s1_sdid_ff <= $signed(sd_d.sd) * id_s;
         s1_cy_ff   <= $signed(sd_d.cy);
         s1_sy_ff   <= $signed(sd_d.sy);
         s1_v_ff    <= v_d;
      end
   end

   // product stage 2
   logic signed [PROD_W-1:0] s2_sec2_ff, s2_tv8_ff, s2_d0_ff, s2_d1_ff, s2_j25_ff, s2_j35_ff;
   logic signed [26:0]       s2_sdv8_ff, s2_cdv8_ff;
   logic signed [Q16_W-1:0]  s2_cy_ff, s2_sy_ff;
   logic signed [15:0]       s2_v_ff;
   logic signed [PROD_W-1:0] sdv8_w, cdv8_w;
   logic signed [63:0]       sec2_w;
   assign sdv8_w = prod_round(P66_W'(s1_sdv_ff), 1'b0);
   assign cdv8_w = prod_round(P66_W'(s1_cdv_ff), 1'b0);
   assign sec2_w = 64'sd65536 + ((s1_sq_ff + 64'sd32768) >>> 16);

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_sec2_ff <= sec2_w[PROD_W-1:0];
         s2_tv8_ff  <= prod_round(P66_W'(s1_tv_ff), 1'b0);
         s2_d0_ff   <= prod_round(P66_W'(s1_cyv_ff), 1'b0);
         s2_d1_ff   <= prod_round(P66_W'(s1_syv_ff), 1'b0);
         s2_sdv8_ff <= sdv8_w[26:0];
         s2_cdv8_ff <= cdv8_w[26:0];
         s2_j25_ff  <= prod_round(P66_W'(s1_til_ff), 1'b1);
         s2_j35_ff  <= prod_round(P66_W'(s1_sdid_ff), 1'b1);
         s2_cy_ff   <= s1_cy_ff;
         s2_sy_ff   <= s1_sy_ff;
         s2_v_ff    <= s1_v_ff;
      end
   end

   // product stage 3: wide operands split at bit 24
   logic signed [39:0] s3_sv_hi_ff;
   logic signed [40:0] s3_sv_lo_ff;
   logic signed [40:0] s3_d2_hi_ff;
   logic signed [41:0] s3_d2_lo_ff;
   logic signed [43:0] s3_d3p_ff, s3_vcdp_ff;
   logic signed [PROD_W-1:0] s3_d0_ff, s3_d1_ff, s3_j25_ff, s3_j35_ff;
   logic signed [Q16_W-1:0]  s3_cy_ff, s3_sy_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_sv_hi_ff <= $signed(s2_sec2_ff[47:24]) * s2_v_ff;
         s3_sv_lo_ff <= $signed({1'b0, s2_sec2_ff[23:0]}) * s2_v_ff;
         s3_d2_hi_ff <= $signed(s2_tv8_ff[47:24]) * il_s;
         s3_d2_lo_ff <= $signed({1'b0, s2_tv8_ff[23:0]}) * il_s;
         s3_d3p_ff   <= s2_sdv8_ff * id_s;
         s3_vcdp_ff  <= s2_cdv8_ff * id_s;
         s3_d0_ff    <= s2_d0_ff;
         s3_d1_ff    <= s2_d1_ff;
         s3_j25_ff   <= s2_j25_ff;
         s3_j35_ff   <= s2_j35_ff;
         s3_cy_ff    <= s2_cy_ff;
         s3_sy_ff    <= s2_sy_ff;
      end
   end

   // product stage 4
   logic signed [P66_W-1:0]  sv_sum, d2_sum;
   logic signed [PROD_W-1:0] s4_sv8_ff, s4_d2_ff, s4_d3_ff, s4_vcd_ff;
   logic signed [PROD_W-1:0] s4_d0_ff, s4_d1_ff, s4_j25_ff, s4_j35_ff;
   logic signed [Q16_W-1:0]  s4_cy_ff, s4_sy_ff;
   assign sv_sum = (P66_W'(s3_sv_hi_ff) <<< 24) + P66_W'(s3_sv_lo_ff);
   assign d2_sum = (P66_W'(s3_d2_hi_ff) <<< 24) + P66_W'(s3_d2_lo_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_sv8_ff <= prod_round(sv_sum, 1'b0);
         s4_d2_ff  <= prod_round(d2_sum, 1'b1);
         s4_d3_ff  <= prod_round(P66_W'(s3_d3p_ff), 1'b1);
         s4_vcd_ff <= prod_round(P66_W'(s3_vcdp_ff), 1'b1);
         s4_d0_ff  <= s3_d0_ff;
         s4_d1_ff  <= s3_d1_ff;
         s4_j25_ff <= s3_j25_ff;
         s4_j35_ff <= s3_j35_ff;
         s4_cy_ff  <= s3_cy_ff;
         s4_sy_ff  <= s3_sy_ff;
      end
   end

   // product stage 5
   logic signed [40:0] s5_j24_hi_ff;
   logic signed [41:0] s5_j24_lo_ff;
   logic signed [PROD_W-1:0] s5_d0_ff, s5_d1_ff, s5_d2_ff, s5_d3_ff, s5_vcd_ff;
   logic signed [PROD_W-1:0] s5_j25_ff, s5_j35_ff;
   logic signed [Q16_W-1:0]  s5_cy_ff, s5_sy_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_j24_hi_ff <= $signed(s4_sv8_ff[47:24]) * il_s;
         s5_j24_lo_ff <= $signed({1'b0, s4_sv8_ff[23:0]}) * il_s;
         s5_d0_ff     <= s4_d0_ff;
         s5_d1_ff     <= s4_d1_ff;
         s5_d2_ff     <= s4_d2_ff;
         s5_d3_ff     <= s4_d3_ff;
         s5_vcd_ff    <= s4_vcd_ff;
         s5_j25_ff    <= s4_j25_ff;
         s5_j35_ff    <= s4_j35_ff;
         s5_cy_ff     <= s4_cy_ff;
         s5_sy_ff     <= s4_sy_ff;
      end
   end

   logic signed [P66_W-1:0]  j24_sum;
   logic signed [PROD_W-1:0] j24;
   assign j24_sum = (P66_W'(s5_j24_hi_ff) <<< 24) + P66_W'(s5_j24_lo_ff);
   assign j24     = prod_round(j24_sum, 1'b1);

   always_comb begin
      load_val[0]  = sat_value(s5_d0_ff);
      load_val[1]  = sat_value(s5_d1_ff);
      load_val[2]  = sat_value(s5_d2_ff);
      load_val[3]  = sat_value(s5_d3_ff);
      load_val[4]  = sat_value(-s5_d1_ff);
      load_val[5]  = sat_value(PROD_W'(s5_cy_ff));
      load_val[6]  = sat_value(s5_d0_ff);
      load_val[7]  = sat_value(PROD_W'(s5_sy_ff));
      load_val[8]  = sat_value(j24);
      load_val[9]  = sat_value(s5_j25_ff);
      load_val[10] = sat_value(-s5_vcd_ff);
      load_val[11] = sat_value(s5_vcd_ff);
      load_val[12] = sat_value(s5_j35_ff);
   end

   // output serializer: load a full set, then advance one word per take
   always_comb begin
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      if (load) begin
         cnt_in = CNT_W'(NUM_RESULTS);
         idx_in = '0;
      end else if (rsp_take) begin
         cnt_in = cnt_ff - CNT_W'(1);
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         idx_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int k = 0; k < NUM_RESULTS; k++) val_ff[k] <= load_val[k];
      end
   end

   assign rsp_ch.valid  = (cnt_ff != '0);
   assign rsp_ch.kind   = RES_KIND[idx_ff];
   assign rsp_ch.row    = RES_ROW[idx_ff];
   assign rsp_ch.column = RES_COL[idx_ff];
   assign rsp_ch.value  = $signed(val_ff[idx_ff]);
   assign rsp_ch.last   = (idx_ff == IDX_W'(NUM_RESULTS - 1));

   `TT_ASSERT_IMPLY(a_load_when_free, clock, reset, load, (cnt_ff == '0) || (cnt_ff == CNT_W'(1) && rsp_ch.ready))
   `TT_ASSERT_NEXT(a_stall_holds_pipe, clock, reset, !adv, $stable(vld_ff))
   `TT_ASSERT_NEXT(a_drain_to_idle, clock, reset, rsp_take && rsp_ch.last && !vld_ff[LAST], !rsp_ch.valid)

endmodule
